// File: hdl/ordered_unique_set_table_defines.svh
// Assertion macros for the set table module.
// They assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef ORDERED_UNIQUE_SET_TABLE_DEFINES_SVH
`define ORDERED_UNIQUE_SET_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define OUST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define OUST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OUST_ASSERT(lbl, prop, msg)
`define OUST_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/ousct_pkg.sv
package ousct_pkg;

  localparam int DATA_W            = 32;
  localparam int REQ_W             = 3;
  localparam int STATUS_W          = 3;
  localparam int COUNT_W           = 7;
  localparam int SUM_W             = 38;
  localparam int DEFAULT_SET_DEPTH = 64;

  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_MEMBER    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic rm_en;
  } cell_ctrl_t;

endpackage

// File: hdl/ousct_cell.sv
module ousct_cell #(
  parameter int CNT_W = 7
) (
  input  logic                            clk,
  input  ousct_pkg::cell_ctrl_t           ctrl,
  input  logic [CNT_W-1:0]                cell_idx,
  input  logic [CNT_W-1:0]                count,
  input  logic [CNT_W-1:0]                rm_pos,
  input  logic [ousct_pkg::DATA_W-1:0]    key,
  input  logic [ousct_pkg::DATA_W-1:0]    right_entry,
  output logic [ousct_pkg::DATA_W-1:0]    entry,
  output logic                            match,
  output logic [ousct_pkg::DATA_W-1:0]    tail_val
);
  import ousct_pkg::*;

  logic [DATA_W-1:0] entry_r;
  logic              match_r;
  logic              tail_r;
  logic              occupied;

  assign occupied = (cell_idx < count);

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match_r <= occupied && (entry_r == key);
      tail_r  <= (cell_idx + CNT_W'(1)) == count;
    end
    // Removal closes the gap: every cell at or above the removed place
    // takes its right neighbour's element.
    if (ctrl.rm_en && (cell_idx >= rm_pos)) begin
      entry_r <= right_entry;
    end else if (ctrl.ins_en && (cell_idx == count)) begin
      entry_r <= key;
    end
  end

  assign entry    = entry_r;
  assign match    = match_r;
  assign tail_val = tail_r ? entry_r : '0;

endmodule

// File: hdl/ordered_unique_set_table.sv
// Insertion-ordered set of unique signed 32-bit values, built as a chain of
// cells, one element per cell, front element in cell zero.
// Input channel: in_valid, in_stall, in_req_type, in_value. A request is taken
// when in_valid is high and in_stall low. Result channel: out_valid,
// out_stall and the result fields; a result is taken when out_valid is high
// and out_stall low. Every request gives exactly one result.
// Each request passes through acceptance, a parallel compare in all
// cells, a locate step that encodes the hit place and picks the popped
// element, and an apply step in which the cells insert or shift and the
// result register is loaded. The result is offered the cycle after apply,
// and a new request is accepted only once the previous one has left its
// apply step.
// If the receiver stalls, the result is held; the next request is still
// accepted and worked on, and it waits in its apply step until the held
// result has been taken.
// Reset empties the table (count and sum zero) and drops any pending result.
module ordered_unique_set_table #(
  parameter int SET_DEPTH = ousct_pkg::DEFAULT_SET_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ousct_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [ousct_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ousct_pkg::STATUS_W-1:0]     out_status,
  output logic                               out_found,
  output logic signed [ousct_pkg::DATA_W-1:0] out_popped_value,
  output logic [ousct_pkg::COUNT_W-1:0]      out_count,
  output logic signed [ousct_pkg::SUM_W-1:0] out_total
);
  import ousct_pkg::*;
  `include "ordered_unique_set_table_defines.svh"

  localparam int CNT_W = $clog2(SET_DEPTH + 1);
  localparam int EXT_W = SUM_W - DATA_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MATCH  = 2'd1;
  localparam logic [1:0] S_LOCATE = 2'd2;
  localparam logic [1:0] S_APPLY  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [REQ_W-1:0]    req_r;
  logic [DATA_W-1:0]   value_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;

  logic                act_ins_r, act_ins_nxt;
  logic                act_rm_r, act_rm_nxt;
  logic [CNT_W-1:0]    rm_pos_r, rm_pos_nxt;
  logic [DATA_W-1:0]   rm_val_r, rm_val_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic                found_r, found_nxt;
  logic [DATA_W-1:0]   popped_r, popped_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  logic [DATA_W-1:0]   out_popped_r;
  logic [CNT_W-1:0]    out_count_r;
  logic [SUM_W-1:0]    out_total_r;

  logic                accept;
  logic                advance;
  cell_ctrl_t          ctrl;

  logic [SET_DEPTH-1:0] match_vec;
  logic [DATA_W-1:0]    entry_vec [SET_DEPTH];
  logic [DATA_W-1:0]    tail_vec  [SET_DEPTH];
  logic                 hit;
  logic [CNT_W-1:0]     hit_pos;
  logic [DATA_W-1:0]    tail_val;

  assign accept  = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign advance = (state_r == S_APPLY) && !(out_valid_r && out_stall);

  assign ctrl.cmp_en = (state_r == S_MATCH);
  assign ctrl.ins_en = advance && act_ins_r;
  assign ctrl.rm_en  = advance && act_rm_r;

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] right_entry;
    if (i == SET_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entry_vec[i+1];
    end
    ousct_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .cell_idx    (CNT_W'(i)),
      .count       (count_r),
      .rm_pos      (rm_pos_r),
      .key         (value_r),
      .right_entry (right_entry),
      .entry       (entry_vec[i]),
      .match       (match_vec[i]),
      .tail_val    (tail_vec[i])
    );
  end

  // The set holds each value once, so at most one cell can match and the
  // OR of the cell indexes is the hit place.
  always_comb begin
    hit_pos  = '0;
    tail_val = '0;
    for (int i = 0; i < SET_DEPTH; i++) begin
      if (match_vec[i]) begin
        hit_pos = hit_pos | CNT_W'(i);
      end
      tail_val = tail_val | tail_vec[i];
    end
    hit = |match_vec;
  end

  always_comb begin
    act_ins_nxt = act_ins_r;
    act_rm_nxt  = act_rm_r;
    rm_pos_nxt  = rm_pos_r;
    rm_val_nxt  = rm_val_r;
    st_nxt      = st_r;
    found_nxt   = found_r;
    popped_nxt  = popped_r;
    if (state_r == S_LOCATE) begin
      act_ins_nxt = 1'b0;
      act_rm_nxt  = 1'b0;
      rm_pos_nxt  = '0;
      rm_val_nxt  = value_r;
      st_nxt      = ST_OK;
      found_nxt   = 1'b0;
      popped_nxt  = '0;
      unique case (req_r)
        REQ_INSERT: begin
          if (hit) begin
            st_nxt    = ST_PRESENT;
            found_nxt = 1'b1;
          end else if (count_r >= CNT_W'(SET_DEPTH)) begin
            st_nxt = ST_FULL;
          end else begin
            act_ins_nxt = 1'b1;
          end
        end
        REQ_DELETE: begin
          if (hit) begin
            found_nxt  = 1'b1;
            act_rm_nxt = 1'b1;
            rm_pos_nxt = hit_pos;
          end else begin
            st_nxt = ST_NOT_FOUND;
          end
        end
        REQ_POP_FRONT: begin
          if (count_r == '0) begin
            st_nxt = ST_EMPTY;
          end else begin
            act_rm_nxt = 1'b1;
            rm_val_nxt = entry_vec[0];
            popped_nxt = entry_vec[0];
          end
        end
        REQ_POP_BACK: begin
          if (count_r == '0) begin
            st_nxt = ST_EMPTY;
          end else begin
            act_rm_nxt = 1'b1;
            rm_pos_nxt = count_r - CNT_W'(1);
            rm_val_nxt = tail_val;
            popped_nxt = tail_val;
          end
        end
        REQ_MEMBER: begin
          if (hit) begin
            found_nxt = 1'b1;
          end else begin
            st_nxt = ST_NOT_FOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (advance) begin
      if (act_ins_r) begin
        count_nxt = count_r + CNT_W'(1);
        sum_nxt   = sum_r + {{EXT_W{value_r[DATA_W-1]}}, value_r};
      end else if (act_rm_r) begin
        count_nxt = count_r - CNT_W'(1);
        sum_nxt   = sum_r - {{EXT_W{rm_val_r[DATA_W-1]}}, rm_val_r};
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_LOCATE;
      end
      S_LOCATE: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (advance) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req_type;
      value_r <= in_value;
    end
    act_ins_r <= act_ins_nxt;
    act_rm_r  <= act_rm_nxt;
    rm_pos_r  <= rm_pos_nxt;
    rm_val_r  <= rm_val_nxt;
    st_r      <= st_nxt;
    found_r   <= found_nxt;
    popped_r  <= popped_nxt;
    if (advance) begin
      out_status_r <= st_r;
      out_found_r  <= found_r;
      out_popped_r <= popped_r;
      out_count_r  <= count_nxt;
      out_total_r  <= sum_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_popped_value = out_popped_r;
  assign out_count        = COUNT_W'(out_count_r);
  assign out_total        = out_total_r;

  `OUST_ASSERT(a_single_match, (state_r == S_LOCATE) |-> $onehot0(match_vec), "more than one cell matched")
  `OUST_ASSERT(a_count_bound, count_r <= CNT_W'(SET_DEPTH), "element count beyond depth")
  `OUST_ASSERT(a_result_from_apply, $rose(out_valid_r) |-> ($past(state_r) == S_APPLY), "result without apply step")
  `OUST_ASSERT(a_count_step, advance |=> ((count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) || (count_r + CNT_W'(1) == $past(count_r))), "count moved by more than one")
  `OUST_ASSERT(a_match_then_locate, (state_r == S_MATCH) |=> (state_r == S_LOCATE), "compare not followed by locate")

endmodule
